>>> design/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

  // widths of the input words as they arrive on the ports
  localparam int unsigned NUM_IN_W = 32;
  localparam int unsigned THR_W    = 32;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } pfc_op_e;

  // request from the sequencer to the shared arithmetic unit
  typedef struct packed {
    logic    start;
    pfc_op_e op;
  } pfc_req_t;

endpackage

`default_nettype wire

>>> design/pfc_arith.sv
`default_nettype none

module pfc_arith #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 19
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfc_pkg::pfc_req_t     req_i,
  input  logic [AW-1:0]         a_i,
  input  logic [BW-1:0]         b_i,
  output logic                  done_o,
  output logic [AW-1:0]         quot_o,
  output logic [BW-1:0]         rem_o,
  output logic [AW+BW-1:0]      prod_o
);
  import pfc_pkg::*;

  localparam int unsigned CntW = $clog2(AW + 1);
  localparam int unsigned PW   = AW + BW;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  pfc_op_e         op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [AW-1:0]   qd_q, qd_d;    // dividend shifting out, quotient shifting in
  logic [BW-1:0]   r_q, r_d;      // partial remainder
  logic [BW-1:0]   b_q, b_d;      // divisor, or multiplier shifting right
  logic [PW-1:0]   mc_q, mc_d;    // multiplicand shifting left
  logic [PW-1:0]   acc_q, acc_d;

  logic [BW:0]     trial;
  logic [BW:0]     diff;
  logic            fits;

  assign trial = {r_q, qd_q[AW-1]};
  assign diff  = trial - {1'b0, b_q};
  assign fits  = trial >= {1'b0, b_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    qd_d   = qd_q;
    r_d    = r_q;
    b_d    = b_q;
    mc_d   = mc_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == OP_DIV) ? CntW'(AW) : CntW'(BW);
      qd_d   = a_i;
      r_d    = '0;
      b_d    = b_i;
      mc_d   = PW'(a_i);
      acc_d  = '0;
    end else if (busy_q) begin
      unique case (op_q)
        OP_DIV: begin
          qd_d = {qd_q[AW-2:0], fits};
          r_d  = fits ? diff[BW-1:0] : trial[BW-1:0];
        end
        OP_MUL: begin
          if (b_q[0]) begin
            acc_d = acc_q + mc_q;
          end
          mc_d = {mc_q[PW-2:0], 1'b0};
          b_d  = {1'b0, b_q[BW-1:1]};
        end
      endcase
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q  <= qd_d;
    r_q   <= r_d;
    b_q   <= b_d;
    mc_q  <= mc_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign quot_o = qd_q;
  assign rem_o  = r_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

>>> design/prime_factor_count_at_least_top.sv
// channel | valid      | ready       | payload
// --------+------------+-------------+--------------------------
// in      | in_valid_i | in_ready_o  | number_i, threshold_i
// out     | out_valid_o| out_ready_i | at_least_o
//
// one word at a time; divides and multiplies run on the single shared
// shift/add unit
// per wheel step: one square, a few powers when the threshold is above 2,
// and one divide per trial plus one per factor found; about 2^(W/2)/6 steps
// worst case
// reset idles the sequencer and empties the output register
// a finished word waits in the output register; the next input is taken
// meanwhile and its result holds until the output register frees up
`default_nettype none

module prime_factor_count_at_least_top #(
  parameter int unsigned NUMBER_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfc_pkg::NUM_IN_W-1:0]  number_i,
  input  logic [pfc_pkg::THR_W-1:0]     threshold_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          at_least_o
);
  import pfc_pkg::*;

  localparam int unsigned NW    = NUMBER_WIDTH;
  localparam int unsigned CW    = (NW + 1) / 2 + 2;
  localparam int unsigned PW    = NW + CW;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  localparam int unsigned DIV_TWO    = 2;
  localparam int unsigned DIV_THREE  = 3;
  localparam int unsigned CAND_FIRST = 5;
  localparam int unsigned CAND_STEP  = 6;
  localparam int unsigned PAIR_GAP   = 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [1:0] KD_STRIP = 2'd0;
  localparam logic [1:0] KD_SQ    = 2'd1;
  localparam logic [1:0] KD_POW   = 2'd2;

  localparam logic [1:0] PH_TWO   = 2'd0;
  localparam logic [1:0] PH_THREE = 2'd1;
  localparam logic [1:0] PH_LO    = 2'd2;
  localparam logic [1:0] PH_HI    = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [1:0]       kind_q, kind_d;
  logic [1:0]       phase_q, phase_d;
  logic             out_valid_q, out_valid_d;
  logic             at_least_q, at_least_d;

  logic [NW-1:0]    rem_q, rem_d;
  logic [THR_W-1:0] need_q, need_d;
  logic [CW-1:0]    cand_q, cand_d;
  logic [NW-1:0]    pow_q, pow_d;
  logic [CNT_W-1:0] lg_q, lg_d;
  logic             res_q, res_d;

  logic [NW-1:0]    num_masked;
  logic [CW-1:0]    divisor;
  logic [THR_W-1:0] need_dec;
  logic             prod_gt_rem;

  pfc_req_t         req;
  logic [NW-1:0]    op_a;
  logic [CW-1:0]    op_b;
  logic             done;
  logic [NW-1:0]    quot;
  logic [CW-1:0]    rmd;
  logic [PW-1:0]    prod;

  if (NW > NUM_IN_W) begin : g_wide
    assign num_masked = {{(NW - NUM_IN_W){1'b0}}, number_i};
  end else begin : g_narrow
    assign num_masked = number_i[NW-1:0];
  end

  always_comb begin
    unique case (phase_q)
      PH_TWO:   divisor = CW'(DIV_TWO);
      PH_THREE: divisor = CW'(DIV_THREE);
      PH_LO:    divisor = cand_q;
      PH_HI:    divisor = cand_q + CW'(PAIR_GAP);
    endcase
  end

  always_comb begin
    req.start = (state_q == ST_ISSUE);
    unique case (kind_q)
      KD_SQ: begin
        req.op = OP_MUL;
        op_a   = NW'(cand_q);
        op_b   = cand_q;
      end
      KD_POW: begin
        req.op = OP_MUL;
        op_a   = pow_q;
        op_b   = cand_q;
      end
      default: begin
        req.op = OP_DIV;
        op_a   = rem_q;
        op_b   = divisor;
      end
    endcase
  end

  pfc_arith #(
    .AW(NW),
    .BW(CW)
  ) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (done),
    .quot_o (quot),
    .rem_o  (rmd),
    .prod_o (prod)
  );

  assign need_dec    = (need_q != '0) ? need_q - THR_W'(1) : '0;
  assign prod_gt_rem = prod > PW'(rem_q);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    phase_d     = phase_q;
    rem_d       = rem_q;
    need_d      = need_q;
    cand_d      = cand_q;
    pow_d       = pow_q;
    lg_d        = lg_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    at_least_d  = at_least_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rem_d  = num_masked;
          need_d = threshold_i;
          if (num_masked <= NW'(1)) begin
            res_d   = 1'b0;
            state_d = ST_OUT;
          end else begin
            kind_d  = KD_STRIP;
            phase_d = PH_TWO;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (done) begin
          state_d = ST_ISSUE;
          unique case (kind_q)
            KD_SQ: begin
              if (prod_gt_rem) begin
                // wheel exhausted: leftover above one is a single prime
                res_d   = (need_q == THR_W'(1));
                state_d = ST_OUT;
              end else if (need_q <= THR_W'(2)) begin
                kind_d  = KD_STRIP;
                phase_d = PH_LO;
              end else begin
                pow_d  = prod[NW-1:0];
                lg_d   = CNT_W'(2);
                kind_d = KD_POW;
              end
            end
            KD_POW: begin
              if (prod_gt_rem) begin
                // remaining factors cannot reach the threshold
                res_d   = 1'b0;
                state_d = ST_OUT;
              end else if (need_q <= THR_W'(lg_q) + THR_W'(1)) begin
                kind_d  = KD_STRIP;
                phase_d = PH_LO;
              end else begin
                pow_d = prod[NW-1:0];
                lg_d  = lg_q + CNT_W'(1);
              end
            end
            default: begin
              if (rmd == '0) begin
                rem_d  = quot;
                need_d = need_dec;
              end else begin
                unique case (phase_q)
                  PH_TWO: phase_d = PH_THREE;
                  PH_LO:  phase_d = PH_HI;
                  default: begin
                    if (need_q == '0) begin
                      res_d   = 1'b1;
                      state_d = ST_OUT;
                    end else if (rem_q == NW'(1)) begin
                      res_d   = 1'b0;
                      state_d = ST_OUT;
                    end else begin
                      cand_d = (phase_q == PH_THREE) ? CW'(CAND_FIRST)
                                                     : cand_q + CW'(CAND_STEP);
                      kind_d = KD_SQ;
                    end
                  end
                endcase
              end
            end
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          at_least_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KD_STRIP;
      phase_q     <= PH_TWO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    need_q     <= need_d;
    cand_q     <= cand_d;
    pow_q      <= pow_d;
    lg_q       <= lg_d;
    res_q      <= res_d;
    at_least_q <= at_least_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign at_least_o  = at_least_q;

endmodule

`default_nettype wire

>>> design/pfc_checker.sv
`default_nettype none

module pfc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [pfc_pkg::NUM_IN_W-1:0] number_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         at_least_o
);
  import pfc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(at_least_o))
    else $error("result word changed while stalled");

  // the block goes busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input still ready after accept");

  // zero or one answers 0 via ST_OUT and then the output register when the output is free
  a_trivial_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (number_i == NUM_IN_W'(0) || number_i == NUM_IN_W'(1))
    |-> ##2 out_valid_o && !at_least_o)
    else $error("number below two did not answer 0 on time");

  // a new result only appears as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result issued while sequencer busy");

endmodule

bind prime_factor_count_at_least_top pfc_checker u_pfc_checker (.*);

`default_nettype wire
